// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of the peer session gate.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== src/psg_pkg.sv =====
// Package for the peer session gate: field widths, operation codes, FSM and control types.
`default_nettype none

package psg_pkg;

  localparam int FUNC_W     = 2;
  localparam int MAC_W      = 48;
  localparam int TIME_W     = 40;
  localparam int TTL_W      = 32;
  localparam int S_TDATA_W  = 96;
  localparam int M_TDATA_W  = 8;

  localparam logic [TTL_W-1:0] TTL_RESET = 32'd1000000;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_BEGIN = 2'd0,
    FUNC_END   = 2'd1,
    FUNC_CHECK = 2'd2,
    FUNC_SWEEP = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_COMMIT
  } psg_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;    // capture the accepted transaction
    logic walk;    // step the table scan
    logic commit;  // write back the table, flags and result
  } psg_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic walk_done;  // every entry has been evaluated
    logic out_free;   // result register can take a new result
  } psg_status_t;

endpackage

`default_nettype wire

// ===== src/peer_session_gate_with_expiry.sv =====
// Top level of the peer session gate with expiry: controller plus datapath.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------------
//  s_axis   | in        | s_tvalid/s_tready  | s_tdata: func, peer_mac, now_time
//  m_axis   | out       | m_tvalid/m_tready  | m_tdata: allowed, arm/disarm, armed, full
//  cfg      | in        | cfg_wr_en          | cfg_wr_data: lifetime in ticks
//
// A result reaches the output register after its transaction is accepted, scanned one
// entry per cycle through the registered read port and committed; the next transaction
// is accepted only after that commit, so transactions never overlap.
// Reset clears the valid bits, the armed flag and the handshake state; the lifetime
// returns to 1000000. The entry memory is not cleared: only valid entries are evaluated.
// A stalled output holds the result; the next transaction is scanned, its commit waits.
`default_nettype none

module peer_session_gate_with_expiry
  import psg_pkg::*;
#(
  parameter int MAX_PEERS = 16
)
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration: lifetime in ticks
  input  wire logic                 cfg_wr_en,
  input  wire logic [TTL_W-1:0]     cfg_wr_data,
  // input stream
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // [1:0] func, [49:2] peer_mac, [89:50] now_time, [95:90] zero
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  // result stream
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // [0] allowed, [1] arm_event, [2] disarm_event, [3] armed_now, [4] table_full,
  // [7:5] zero
  output logic [M_TDATA_W-1:0]      m_tdata
);

  psg_cmd_t    cmd;
  psg_status_t status;

  // Sequencing: accept, scan, commit.
  psg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Table storage, purge/match scan and result register.
  psg_datapath #(
    .MAX_PEERS (MAX_PEERS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

`default_nettype wire

// ===== src/psg_ctrl.sv =====
// Controller state machine of the peer session gate.
`default_nettype none

module psg_ctrl
  import psg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire psg_status_t status,
  output psg_cmd_t         cmd
);

  psg_state_t state;
  psg_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (status.walk_done) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // hold until the result register frees up
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/psg_datapath.sv =====
// Datapath of the peer session gate: entry memory, valid bits, scan logic and result register.
`default_nettype none

module psg_datapath
  import psg_pkg::*;
#(
  parameter int MAX_PEERS = 16
)
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [TTL_W-1:0]     cfg_wr_data,
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata,
  input  wire psg_cmd_t             cmd,
  output psg_status_t               status
);

  localparam int IDX_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int CNT_W = $clog2(MAX_PEERS + 1);
  localparam int ENT_W = MAC_W + TIME_W;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(MAX_PEERS);

  // Configuration and captured transaction
  logic [TTL_W-1:0]  ttl;
  func_t             op;
  logic [MAC_W-1:0]  peer;
  logic [TIME_W-1:0] now;
  logic [TIME_W-1:0] deadline;

  // Table state
  logic [ENT_W-1:0]     mem [MAX_PEERS];
  logic [MAX_PEERS-1:0] valid;
  logic                 armed;

  // Scan state
  logic [CNT_W-1:0] rd_cnt;
  logic             rd_en;
  logic [ENT_W-1:0] rd_data;
  logic             ev_vld;
  logic [IDX_W-1:0] ev_idx;
  logic             found;
  logic [IDX_W-1:0] hit_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             any_live;

  // Evaluation of the entry under the scan
  logic              purge_op;
  logic              ev_valid;
  logic              ev_expired;
  logic              ev_live;
  logic              ev_hit;
  logic [MAC_W-1:0]  ev_mac;
  logic [TIME_W-1:0] ev_deadline;
  logic [TIME_W:0]   dl_sum;

  // Commit decisions
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic             set_valid;
  logic             res_allowed;
  logic             res_arm;
  logic             res_disarm;
  logic             res_full;
  logic             armed_next;

  assign dl_sum      = {1'b0, s_tdata[FUNC_W+MAC_W +: TIME_W]} + {{(TIME_W+1-TTL_W){1'b0}}, ttl};
  assign rd_en       = cmd.walk && (rd_cnt != LAST);
  assign purge_op    = (op != FUNC_END);
  assign ev_mac      = rd_data[ENT_W-1:TIME_W];
  assign ev_deadline = rd_data[TIME_W-1:0];
  assign ev_valid    = ev_vld && valid[ev_idx];
  assign ev_expired  = purge_op && ev_valid && (ev_deadline <= now);
  assign ev_live     = ev_valid && !ev_expired;
  assign ev_hit      = ev_live && (ev_mac == peer);

  assign status.walk_done = (rd_cnt == LAST) && !ev_vld;
  assign status.out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ttl <= TTL_RESET;
    end else if (cfg_wr_en) begin
      ttl <= cfg_wr_data;
    end
  end

  // Capture the transaction; saturate the deadline at the top of the time range.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= func_t'(s_tdata[FUNC_W-1:0]);
      peer     <= s_tdata[FUNC_W +: MAC_W];
      now      <= s_tdata[FUNC_W+MAC_W +: TIME_W];
      deadline <= dl_sum[TIME_W] ? {TIME_W{1'b1}} : dl_sum[TIME_W-1:0];
    end
  end

  // Scan pointer and registered memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt <= '0;
      ev_vld <= 1'b0;
    end else if (cmd.load) begin
      rd_cnt <= '0;
      ev_vld <= 1'b0;
    end else begin
      ev_vld <= rd_en;
      if (rd_en) begin
        rd_cnt <= rd_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_cnt[IDX_W-1:0]];
      ev_idx  <= rd_cnt[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= {peer, deadline};
    end
  end

  // Scan summary: first live match, first free slot, any entry left live
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      found      <= 1'b0;
      free_found <= 1'b0;
      any_live   <= 1'b0;
    end else if (ev_vld) begin
      if (ev_hit && !found) begin
        found   <= 1'b1;
        hit_idx <= ev_idx;
      end
      if (!ev_live && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= ev_idx;
      end
      if (ev_live && !(op == FUNC_END && ev_hit)) begin
        any_live <= 1'b1;
      end
    end
  end

  always_comb begin
    wr_en       = 1'b0;
    wr_idx      = hit_idx;
    set_valid   = 1'b0;
    res_allowed = 1'b0;
    res_arm     = 1'b0;
    res_disarm  = 1'b0;
    res_full    = 1'b0;
    armed_next  = armed;
    if (op == FUNC_BEGIN) begin
      if (found) begin
        wr_en = 1'b1;
      end else if (free_found) begin
        wr_en     = 1'b1;
        wr_idx    = free_idx;
        set_valid = 1'b1;
      end else begin
        res_full = 1'b1;
      end
      if (!armed) begin
        res_arm    = 1'b1;
        armed_next = 1'b1;
      end
    end else begin
      if (armed && !any_live) begin
        res_disarm = 1'b1;
        armed_next = 1'b0;
      end
      res_allowed = (op == FUNC_CHECK) && found;
    end
    wr_en = wr_en && cmd.commit;
  end

  // Valid bits: drop expired and ended entries during the scan, mark inserts at commit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      armed <= 1'b0;
    end else begin
      if (ev_vld && (ev_expired || (op == FUNC_END && ev_hit))) begin
        valid[ev_idx] <= 1'b0;
      end
      if (cmd.commit) begin
        if (set_valid) begin
          valid[wr_idx] <= 1'b1;
        end
        armed <= armed_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {3'b000, res_full, armed_next, res_disarm, res_arm, res_allowed};
    end
  end

endmodule

`default_nettype wire

// ===== src/psg_checker.sv =====
// Port-level checker for the peer session gate, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module psg_port_checker
  import psg_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [M_TDATA_W-1:0] m_tdata
);

  // A pending result stays offered until taken.
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)

  // One transaction at a time: no acceptance right after an acceptance.
  `ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready)

  // Arm and disarm never happen on the same transaction.
  `ASSERT_IMPLIES(a_arm_excl, clk, rst, m_tvalid, !(m_tdata[1] && m_tdata[2]))

  // Events agree with the reported armed flag.
  `ASSERT_IMPLIES(a_arm_flag, clk, rst, m_tvalid && (m_tdata[1] || m_tdata[2]),
                  m_tdata[3] == m_tdata[1])

endmodule

bind peer_session_gate_with_expiry psg_port_checker u_chk (.*);

`default_nettype wire
